// ----- hdl/gsm_septet_pack_unpack_unit_defines.svh -----
// ----------------------------------------------------------------------------
// GSM septet codec assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef GSM_SEPTET_PACK_UNPACK_UNIT_DEFINES_SVH
`define GSM_SEPTET_PACK_UNPACK_UNIT_DEFINES_SVH

// same-cycle implication
`define GSPU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gspu assertion failed");

// next-cycle implication
`define GSPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gspu assertion failed");

`endif

// ----- hdl/gspu_pkg.sv -----
// ----------------------------------------------------------------------------
// gspu_pkg
// Types and constants shared by the GSM septet codec.
// ----------------------------------------------------------------------------
package gspu_pkg;

  localparam int OUTQ_DEPTH = 4;

  localparam logic [3:0] SEPTET_BITS = 4'd7;
  localparam logic [3:0] OCTET_BITS  = 4'd8;
  localparam logic [3:0] GROUP_BITS  = 4'd14;
  localparam logic [6:0] SEPTET_MASK = 7'h7F;

  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  typedef struct packed {
    logic [7:0] in_value;
    logic [7:0] char_count;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       out_last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } push_t;

endpackage

// ----- hdl/gspu_step.sv -----
// ----------------------------------------------------------------------------
// gspu_step
// Message state and the combinational pack/unpack step for one input word.
// ----------------------------------------------------------------------------
module gspu_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic              fire,
  input  gspu_pkg::in_word_t itm,
  output gspu_pkg::push_t   push
);
  import gspu_pkg::*;
  `include "gsm_septet_pack_unpack_unit_defines.svh"

  logic        dir;
  logic [6:0]  bit_store;
  logic [2:0]  held;
  logic [7:0]  chars_done;
  logic [7:0]  length_held;
  logic        in_message;

  logic [6:0]  bit_store_next;
  logic [2:0]  held_next;
  logic [7:0]  chars_done_next;
  logic [7:0]  length_held_next;
  logic        in_message_next;

  logic [7:0]  base_chars;
  logic [7:0]  len;
  logic [7:0]  cd1;
  logic [7:0]  cd2;
  logic [7:0]  v;
  logic [14:0] sum;
  logic [3:0]  hsum;
  logic [3:0]  hrem;
  logic        done1;
  logic        last1;
  logic        clr;

  always_comb begin
    base_chars = in_message ? chars_done : 8'd0;
    len        = in_message ? length_held : itm.char_count;
    cd1        = base_chars + 8'd1;
    cd2        = base_chars + 8'd2;
    done1      = (cd1 == len);
    v          = (dir == DIR_UNPACK) ? itm.in_value : {1'b0, itm.in_value[6:0] & SEPTET_MASK};
    sum        = {8'd0, bit_store} | ({7'd0, v} << held);
    hsum       = {1'b0, held} + ((dir == DIR_UNPACK) ? OCTET_BITS : SEPTET_BITS);
    hrem       = '0;
    last1      = 1'b0;
    clr        = 1'b0;

    push             = '0;
    bit_store_next   = bit_store;
    held_next        = held;
    chars_done_next  = chars_done;
    length_held_next = length_held;
    in_message_next  = in_message;

    if (fire) begin
      chars_done_next  = cd1;
      length_held_next = len;
      in_message_next  = 1'b1;
      if (dir == DIR_PACK) begin
        if (hsum >= OCTET_BITS) begin
          hrem       = hsum - OCTET_BITS;
          push.count = 2'd1;
          push.first = '{out_value: sum[7:0], out_last: 1'b0};
          if (done1) begin
            clr = 1'b1;
            if (hrem != 4'd0) begin
              push.count  = 2'd2;
              push.second = '{out_value: {1'b0, sum[14:8]}, out_last: 1'b1};
            end else begin
              push.first.out_last = 1'b1;
            end
          end else begin
            bit_store_next = sum[14:8];
            held_next      = hrem[2:0];
          end
        end else begin
          if (done1) begin
            clr        = 1'b1;
            push.count = 2'd1;
            push.first = '{out_value: {1'b0, sum[6:0]}, out_last: 1'b1};
          end else begin
            bit_store_next = sum[6:0];
            held_next      = SEPTET_BITS[2:0];
          end
        end
      end else begin
        hrem       = hsum - SEPTET_BITS;
        push.count = 2'd1;
        push.first = '{out_value: {1'b0, sum[6:0]}, out_last: done1};
        if (done1) begin
          clr = 1'b1;
        end else if (hsum >= GROUP_BITS) begin
          // group-final octet: second septet; reaching the length or a zero ends the message
          last1       = (cd2 == len) || (sum[13:7] == 7'd0);
          push.count  = 2'd2;
          push.second = '{out_value: {1'b0, sum[13:7]}, out_last: last1};
          clr         = last1;
          bit_store_next  = 7'd0;
          held_next       = 3'd0;
          chars_done_next = cd2;
        end else begin
          bit_store_next = sum[13:7];
          held_next      = hrem[2:0];
        end
      end
      if (clr) begin
        bit_store_next   = '0;
        held_next        = '0;
        chars_done_next  = '0;
        length_held_next = '0;
        in_message_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir         <= DIR_PACK;
      bit_store   <= '0;
      held        <= '0;
      chars_done  <= '0;
      length_held <= '0;
      in_message  <= 1'b0;
    end else if (cfg_we) begin
      dir         <= cfg_data;
      bit_store   <= '0;
      held        <= '0;
      chars_done  <= '0;
      length_held <= '0;
      in_message  <= 1'b0;
    end else begin
      bit_store   <= bit_store_next;
      held        <= held_next;
      chars_done  <= chars_done_next;
      length_held <= length_held_next;
      in_message  <= in_message_next;
    end
  end

  `GSPU_ASSERT_NOW(a_unpack_always_emits, fire && dir == DIR_UNPACK, push.count != 2'd0)
  `GSPU_ASSERT_NEXT(a_pack_pair_ends_msg,
    fire && !cfg_we && dir == DIR_PACK && push.count == 2'd2, !in_message)
  `GSPU_ASSERT_NOW(a_idle_state_clear, !in_message, chars_done == 8'd0 && held == 3'd0)

endmodule

// ----- hdl/gspu_outq.sv -----
// ----------------------------------------------------------------------------
// gspu_outq
// Small result queue: takes up to two words a cycle, hands out one unless stalled.
// ----------------------------------------------------------------------------
module gspu_outq #(
  parameter int DEPTH = gspu_pkg::OUTQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  gspu_pkg::push_t    push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output gspu_pkg::out_word_t out_word
);
  import gspu_pkg::*;
  `include "gsm_septet_pack_unpack_unit_defines.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_word_t          mem [DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   count;

  logic [PTR_W-1:0]   rd_ptr_next;
  logic [PTR_W-1:0]   wr1;
  logic [PTR_W-1:0]   wr2;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [CNT_W-1:0]   count_next;
  logic               pop;

  always_comb begin
    pop         = out_valid && !out_stall;
    wr1         = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
    wr2         = (wr1 == PTR_W'(DEPTH - 1)) ? '0 : wr1 + PTR_W'(1);
    rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    case (push.count)
      2'd1:    wr_ptr_next = wr1;
      2'd2:    wr_ptr_next = wr2;
      default: wr_ptr_next = wr_ptr;
    endcase
    count_next = count + CNT_W'(push.count) - CNT_W'(pop);
  end

  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr1] <= push.second;
    end
  end

  `GSPU_ASSERT_NOW(a_push_fits, push.count != 2'd0, room)
  `GSPU_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `GSPU_ASSERT_NEXT(a_count_track, 1'b1,
    count == $past(count) + CNT_W'($past(push.count)) - CNT_W'($past(pop)))

endmodule

// ----- hdl/gsm_septet_pack_unpack_unit.sv -----
// ----------------------------------------------------------------------------
// gsm_septet_pack_unpack_unit
// GSM 7-bit septet packer/unpacker, streaming, one word per cycle when not stalled.
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+---------------------------
//   in      | in  | in_valid/in_stall  | in_value, char_count
//   out     | out | out_valid/out_stall| out_value, out_last
//   cfg     | in  | cfg_we             | cfg_data (direction)
//
// Input word is registered, stepped combinationally, results go to a queue.
// A word waits in its register for queue room; its results are then queued and offered.
// One input word per cycle while the output drains; two-result words
// bound the sustained rate by the one-word-per-cycle output port.
// in_stall is high while a word waits and the queue lacks room for two more.
// rst is synchronous; it clears direction, message state and the queue.
// ----------------------------------------------------------------------------
module gsm_septet_pack_unpack_unit #(
  parameter int OUTQ_DEPTH = gspu_pkg::OUTQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  gspu_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output gspu_pkg::out_word_t out_word
);
  import gspu_pkg::*;

  in_word_t itm;
  logic     itm_valid;
  logic     itm_valid_next;
  logic     room;
  logic     fire;
  logic     accept;
  push_t    push;

  assign fire           = itm_valid && room;
  assign in_stall       = itm_valid && !room;
  assign accept         = in_valid && !in_stall;
  assign itm_valid_next = accept || (itm_valid && !fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      itm_valid <= 1'b0;
    end else begin
      itm_valid <= itm_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      itm <= in_word;
    end
  end

  gspu_step u_step (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .fire     (fire),
    .itm      (itm),
    .push     (push)
  );

  gspu_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
